### rtl/core/tcce_pkg.sv
// Shared constants, types and codes for the text console character engine.
`default_nettype none

package tcce_pkg;

  // Screen geometry.
  localparam int unsigned COLUMNS = 80;
  localparam int unsigned ROWS    = 25;
  localparam int unsigned CELLS   = COLUMNS * ROWS;

  // Widths of internal values.
  localparam int unsigned ADDR_W = $clog2(CELLS);
  localparam int unsigned COL_W  = $clog2(COLUMNS + 8);
  localparam int unsigned ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int unsigned FCNT_W = $clog2(COLUMNS);

  // Widths of the port fields.
  localparam int unsigned OP_W   = 2;
  localparam int unsigned CHAR_W = 8;
  localparam int unsigned IDX_W  = 11;
  localparam int unsigned ATTR_W = 8;
  localparam int unsigned CELL_W = 16;
  localparam int unsigned POS_W  = 11;
  localparam int unsigned BSM_W  = 7;
  localparam int unsigned CMP_W  = (COL_W > BSM_W) ? COL_W : BSM_W;

  // Reciprocal of the column count for splitting a cell index into row and column.
  localparam int unsigned RECIP_SH = IDX_W + 4;
  localparam int unsigned RECIP    = (2 ** RECIP_SH) / COLUMNS;

  // Request queue between the front and back parts.
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  // Configuration port.
  localparam int unsigned PADDR_W = 3;
  localparam int unsigned REG_W   = PADDR_W - 2;
  localparam int unsigned PDATA_W = 32;
  localparam logic [REG_W-1:0] REG_TEXT_COLOR = 1'b0;
  localparam logic [REG_W-1:0] REG_BS_MIN     = 1'b1;

  // Reset values and character codes.
  localparam logic [ATTR_W-1:0] RST_ATTR   = 8'h0F;
  localparam logic [BSM_W-1:0]  RST_BS_MIN = 7'd18;
  localparam logic [CHAR_W-1:0] SPACE      = 8'h20;
  localparam logic [CHAR_W-1:0] CH_BS      = 8'h08;
  localparam logic [CHAR_W-1:0] CH_TAB     = 8'h09;
  localparam logic [CHAR_W-1:0] CH_LF      = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CR      = 8'h0D;
  localparam logic [CHAR_W-1:0] PRINT_LO   = 8'h20;
  localparam logic [CHAR_W-1:0] PRINT_HI   = 8'h7F;
  localparam int unsigned       TAB_STEP   = 8;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_PUT   = 2'd0;
  localparam logic [OP_W-1:0] OP_READ  = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

  // Classified request kinds.
  typedef enum logic [2:0] {
    K_NONE,
    K_PRINT,
    K_BS,
    K_TAB,
    K_CR,
    K_LF,
    K_READ,
    K_CLEAR
  } kind_t;

  typedef struct packed {
    kind_t             kind;
    logic [CHAR_W-1:0] ch;
    logic [IDX_W-1:0]  idx;
  } cmd_t;

  typedef struct packed {
    logic [ATTR_W-1:0] text_color;
    logic [BSM_W-1:0]  bs_min;
  } cfg_t;

  typedef struct packed {
    logic [CELL_W-1:0] cell_data;
    logic [POS_W-1:0]  pos;
  } rsp_t;

endpackage

`default_nettype wire

### rtl/core/text_console_character_engine_top.sv
// Top level of the text console character engine with its configuration registers.
// A request without a row fill gives done after the execute and report states, a cell read
// after the multiply, product, address, wait and report states; one that writes into a row
// left blank by reset, clear or scroll first sweeps that row through the single store
// write port. Requests queue while one runs; busy is high only while the queue is full.
// Synchronous reset homes the cursor, restores the registers, and marks every row
// blank in attribute 0x0F, so the screen reads as spaces with no clearing pass.
`default_nettype none

module text_console_character_engine_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [tcce_pkg::OP_W-1:0]     opcode,
  input  logic [tcce_pkg::CHAR_W-1:0]   char_code,
  input  logic [tcce_pkg::IDX_W-1:0]    read_index,
  output logic                          done,
  output logic [tcce_pkg::CELL_W-1:0]   cell_value,
  output logic [tcce_pkg::POS_W-1:0]    cursor_position,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tcce_pkg::PADDR_W-1:0]  paddr,
  input  logic [tcce_pkg::PDATA_W-1:0]  pwdata,
  output logic [tcce_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready
);

  import tcce_pkg::*;

  cfg_t             cfg;
  cmd_t             f_cmd;
  cmd_t             q_cmd;
  rsp_t             rsp;
  logic             push;
  logic             pop;
  logic             q_full;
  logic             q_empty;
  logic [REG_W-1:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[PADDR_W-1:2];
  assign busy    = q_full;

  // Configuration register writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.text_color <= RST_ATTR;
      cfg.bs_min     <= RST_BS_MIN;
    end else if (psel && penable && pwrite && pready) begin
      case (reg_idx)
        REG_TEXT_COLOR: cfg.text_color <= pwdata[ATTR_W-1:0];
        REG_BS_MIN:     cfg.bs_min     <= pwdata[BSM_W-1:0];
        default:        cfg.bs_min     <= cfg.bs_min;
      endcase
    end
  end

  // Configuration register reads.
  always_comb begin
    case (reg_idx)
      REG_TEXT_COLOR: prdata = PDATA_W'(cfg.text_color);
      REG_BS_MIN:     prdata = PDATA_W'(cfg.bs_min);
      default:        prdata = '0;
    endcase
  end

  tcce_front u_front (
    .start      (start),
    .full       (q_full),
    .opcode     (opcode),
    .char_code  (char_code),
    .read_index (read_index),
    .push       (push),
    .cmd        (f_cmd)
  );

  tcce_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .cmd_in  (f_cmd),
    .pop     (pop),
    .cmd_out (q_cmd),
    .full    (q_full),
    .empty   (q_empty)
  );

  tcce_back u_back (
    .clk   (clk),
    .rst   (rst),
    .cfg   (cfg),
    .empty (q_empty),
    .q_cmd (q_cmd),
    .pop   (pop),
    .done  (done),
    .rsp   (rsp)
  );

  assign cell_value      = rsp.cell_data;
  assign cursor_position = rsp.pos;

endmodule

`default_nettype wire

### rtl/core/tcce_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none

module tcce_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### rtl/core/tcce_front.sv
// Front part: accepts requests and classifies them into command kinds.
`default_nettype none

module tcce_front (
  input  logic                      start,
  input  logic                      full,
  input  logic [tcce_pkg::OP_W-1:0]   opcode,
  input  logic [tcce_pkg::CHAR_W-1:0] char_code,
  input  logic [tcce_pkg::IDX_W-1:0]  read_index,
  output logic                      push,
  output tcce_pkg::cmd_t            cmd
);

  import tcce_pkg::*;

  // A request is taken whenever the queue has room.
  assign push = start & ~full;

  // Decode the operation and the character byte.
  always_comb begin
    cmd.ch  = char_code;
    cmd.idx = read_index;
    case (opcode)
      OP_PUT: begin
        case (char_code)
          CH_BS:   cmd.kind = K_BS;
          CH_TAB:  cmd.kind = K_TAB;
          CH_CR:   cmd.kind = K_CR;
          CH_LF:   cmd.kind = K_LF;
          default: begin
            if (char_code inside {[PRINT_LO:PRINT_HI]}) begin
              cmd.kind = K_PRINT;
            end else begin
              cmd.kind = K_NONE;
            end
          end
        endcase
      end
      OP_READ:  cmd.kind = K_READ;
      OP_CLEAR: cmd.kind = K_CLEAR;
      default:  cmd.kind = K_NONE;
    endcase
  end

endmodule

`default_nettype wire

### rtl/core/tcce_queue.sv
// Short request queue between the front and back parts.
`default_nettype none

module tcce_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  tcce_pkg::cmd_t cmd_in,
  input  logic           pop,
  output tcce_pkg::cmd_t cmd_out,
  output logic           full,
  output logic           empty
);

  import tcce_pkg::*;

  logic [QPTR_W-1:0] wptr;
  logic [QPTR_W-1:0] rptr;
  logic [QCNT_W-1:0] count;
  cmd_t              slots [QDEPTH];

  assign full    = (count == QCNT_W'(QDEPTH));
  assign empty   = (count == '0);
  assign cmd_out = slots[rptr];

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == QPTR_W'(QDEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == QPTR_W'(QDEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= cmd_in;
    end
  end

endmodule

`default_nettype wire

### rtl/core/tcce_back.sv
// Back part: executes commands against the screen store and reports results.
`default_nettype none

module tcce_back (
  input  logic           clk,
  input  logic           rst,
  input  tcce_pkg::cfg_t cfg,
  input  logic           empty,
  input  tcce_pkg::cmd_t q_cmd,
  output logic           pop,
  output logic           done,
  output tcce_pkg::rsp_t rsp
);

  import tcce_pkg::*;

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_FILL    = 3'd1;
  localparam logic [2:0] S_EXEC    = 3'd2;
  localparam logic [2:0] S_RD_MUL  = 3'd3;
  localparam logic [2:0] S_RD_PROD = 3'd4;
  localparam logic [2:0] S_RD_ADDR = 3'd5;
  localparam logic [2:0] S_RD_WAIT = 3'd6;
  localparam logic [2:0] S_REPORT  = 3'd7;

  localparam int unsigned QM_W  = IDX_W + RECIP_SH;
  localparam int unsigned SUM_W = ((IDX_W > ADDR_W) ? IDX_W : ADDR_W) + 1;

  logic [2:0]        state;
  cmd_t              cmd;
  logic [COL_W-1:0]  col;
  logic [ROW_W-1:0]  row;
  logic [ADDR_W-1:0] log_base;
  logic [ROW_W-1:0]  cur_prow;
  logic [ADDR_W-1:0] cur_base;
  logic [ROW_W-1:0]  top;
  logic [ADDR_W-1:0] top_base;
  logic [ROWS-1:0]   blank_row;
  logic [ATTR_W-1:0] row_attr [ROWS];
  logic [FCNT_W-1:0] fcnt;

  logic [IDX_W-1:0]  q_est;
  logic [IDX_W-1:0]  prod;
  logic [ADDR_W-1:0] phys_addr;
  logic              in_range;
  logic              blank_hit;
  logic [ATTR_W-1:0] blank_attr;
  logic [CELL_W-1:0] cell_r;

  logic              bs_act;
  logic              needs_wr;
  logic [COL_W-1:0]  col_new;
  logic [COL_W-1:0]  col_fin;
  logic              row_step;
  logic              we;
  logic [ADDR_W-1:0] waddr;
  logic [CELL_W-1:0] wdata;
  logic [CELL_W-1:0] rdata;
  logic [ROW_W-1:0]  attr_idx;
  logic [ATTR_W-1:0] attr_rd;
  logic [QM_W-1:0]   qmul;
  logic [SUM_W-1:0]  psum_addr;
  logic [IDX_W-1:0]  rem;
  logic [IDX_W-1:0]  q_fix;
  logic [IDX_W:0]    psum_row;
  logic [ROW_W-1:0]  rd_prow;
  logic [ADDR_W-1:0] pos_sum;

  // Advance a physical row base by one row, wrapping around the store.
  function automatic logic [ADDR_W-1:0] base_step(input logic [ADDR_W-1:0] b);
    logic [ADDR_W:0] s;
    s = {1'b0, b} + (ADDR_W+1)'(COLUMNS);
    if (s >= (ADDR_W+1)'(CELLS)) begin
      s = s - (ADDR_W+1)'(CELLS);
    end
    return s[ADDR_W-1:0];
  endfunction

  // Advance a physical row number by one, wrapping around the screen.
  function automatic logic [ROW_W-1:0] row_inc(input logic [ROW_W-1:0] r);
    return (r == ROW_W'(ROWS - 1)) ? '0 : r + 1'b1;
  endfunction

  // Screen store, kept in physical row order with a rotating top row.
  tcce_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELLS)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (phys_addr),
    .rdata (rdata)
  );

  // Backspace acts only right of the configured minimum column.
  assign bs_act   = (CMP_W'(col) > CMP_W'(cfg.bs_min)) && (col != '0);
  assign needs_wr = (q_cmd.kind == K_PRINT) || ((q_cmd.kind == K_BS) && bs_act);
  assign pop      = (state == S_IDLE) && !empty;

  // Blank attribute of one row, shared by the fill sweep and the read path.
  assign attr_idx = (state == S_RD_ADDR) ? rd_prow : cur_prow;
  assign attr_rd  = row_attr[attr_idx];

  // Cursor update for a put request.
  always_comb begin
    col_new  = col;
    row_step = 1'b0;
    case (cmd.kind)
      K_PRINT: col_new = col + 1'b1;
      K_BS:    col_new = bs_act ? col - 1'b1 : col;
      K_TAB:   col_new = (col + COL_W'(TAB_STEP)) & ~COL_W'(TAB_STEP - 1);
      K_CR:    col_new = '0;
      K_LF: begin
        col_new  = '0;
        row_step = 1'b1;
      end
      default: col_new = col;
    endcase
    col_fin = col_new;
    if (col_new >= COL_W'(COLUMNS)) begin
      col_fin  = '0;
      row_step = 1'b1;
    end
  end

  // Store write port: row fill sweep or the cell write of a put request.
  always_comb begin
    we    = 1'b0;
    waddr = cur_base + ADDR_W'(col);
    wdata = {cfg.text_color, SPACE};
    case (state)
      S_FILL: begin
        we    = 1'b1;
        waddr = cur_base + ADDR_W'(fcnt);
        wdata = {attr_rd, SPACE};
      end
      S_EXEC: begin
        if (cmd.kind == K_PRINT) begin
          we    = 1'b1;
          wdata = {cfg.text_color, cmd.ch};
        end else if ((cmd.kind == K_BS) && bs_act) begin
          we    = 1'b1;
          waddr = cur_base + ADDR_W'(col) - 1'b1;
        end
      end
      default: we = 1'b0;
    endcase
  end

  // Read path: split the index into row and column and locate the cell.
  always_comb begin
    qmul      = QM_W'(cmd.idx) * QM_W'(RECIP);
    psum_addr = SUM_W'(cmd.idx) + SUM_W'(top_base);
    if (psum_addr >= SUM_W'(CELLS)) begin
      psum_addr = psum_addr - SUM_W'(CELLS);
    end
    rem   = cmd.idx - prod;
    q_fix = (rem >= IDX_W'(COLUMNS)) ? q_est + 1'b1 : q_est;
    psum_row = (IDX_W+1)'(q_fix) + (IDX_W+1)'(top);
    if (psum_row >= (IDX_W+1)'(ROWS)) begin
      psum_row = psum_row - (IDX_W+1)'(ROWS);
    end
    rd_prow = psum_row[ROW_W-1:0];
    pos_sum = log_base + ADDR_W'(col);
  end

  // Control sequencer and cursor state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      done      <= 1'b0;
      col       <= '0;
      row       <= '0;
      log_base  <= '0;
      cur_prow  <= '0;
      cur_base  <= '0;
      top       <= '0;
      top_base  <= '0;
      blank_row <= '1;
      fcnt      <= '0;
      for (int i = 0; i < ROWS; i++) begin
        row_attr[i] <= RST_ATTR;
      end
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (!empty) begin
            cmd    <= q_cmd;
            cell_r <= '0;
            fcnt   <= '0;
            if (q_cmd.kind == K_READ) begin
              state <= S_RD_MUL;
            end else if (needs_wr && blank_row[cur_prow]) begin
              state <= S_FILL;
            end else begin
              state <= S_EXEC;
            end
          end
        end
        S_FILL: begin
          fcnt <= fcnt + 1'b1;
          if (fcnt == FCNT_W'(COLUMNS - 1)) begin
            blank_row[cur_prow] <= 1'b0;
            state               <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (cmd.kind == K_CLEAR) begin
            col       <= '0;
            row       <= '0;
            log_base  <= '0;
            cur_prow  <= '0;
            cur_base  <= '0;
            top       <= '0;
            top_base  <= '0;
            blank_row <= '1;
            for (int i = 0; i < ROWS; i++) begin
              row_attr[i] <= cfg.text_color;
            end
          end else begin
            col <= col_fin;
            if (row_step) begin
              cur_prow <= row_inc(cur_prow);
              cur_base <= base_step(cur_base);
              if (row == ROW_W'(ROWS - 1)) begin
                // Scroll: the old top row becomes the blank bottom row.
                top            <= row_inc(top);
                top_base       <= base_step(top_base);
                blank_row[top] <= 1'b1;
                row_attr[top]  <= cfg.text_color;
              end else begin
                row      <= row + 1'b1;
                log_base <= log_base + ADDR_W'(COLUMNS);
              end
            end
          end
          state <= S_REPORT;
        end
        S_RD_MUL: begin
          q_est     <= qmul[QM_W-1:RECIP_SH];
          in_range  <= (32'(cmd.idx) < 32'(CELLS));
          phys_addr <= psum_addr[ADDR_W-1:0];
          state     <= S_RD_PROD;
        end
        S_RD_PROD: begin
          prod  <= IDX_W'(q_est * IDX_W'(COLUMNS));
          state <= S_RD_ADDR;
        end
        S_RD_ADDR: begin
          blank_hit  <= blank_row[rd_prow];
          blank_attr <= attr_rd;
          state      <= S_RD_WAIT;
        end
        S_RD_WAIT: begin
          if (!in_range) begin
            cell_r <= '0;
          end else if (blank_hit) begin
            cell_r <= {blank_attr, SPACE};
          end else begin
            cell_r <= rdata;
          end
          state <= S_REPORT;
        end
        S_REPORT: begin
          done          <= 1'b1;
          rsp.cell_data <= cell_r;
          rsp.pos       <= POS_W'(pos_sum);
          state         <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

### dv/tb_top.sv
// Self-checking testbench for the text console character engine: directed and random requests.
`timescale 1ns / 100ps

module tb_top;
  import tcce_pkg::*;

  // Opcode 3 is left unused by the block and must change nothing.
  localparam logic [OP_W-1:0] OP_IDLE = 2'd3;
  localparam int unsigned RANDOM_PHASES = 6;
  localparam int unsigned PHASE_ITEMS   = 105;
  localparam int unsigned SETTLE_CYCLES = 120;
  localparam int unsigned MAX_REPORTS   = 10;

  logic                clk        = 1'b0;
  logic                rst        = 1'b1;
  logic                start      = 1'b0;
  logic                busy;
  logic [OP_W-1:0]     opcode     = OP_PUT;
  logic [CHAR_W-1:0]   char_code  = '0;
  logic [IDX_W-1:0]    read_index = '0;
  logic                done;
  logic [CELL_W-1:0]   cell_value;
  logic [POS_W-1:0]    cursor_position;
  logic                psel       = 1'b0;
  logic                penable    = 1'b0;
  logic                pwrite     = 1'b0;
  logic [PADDR_W-1:0]  paddr      = '0;
  logic [PDATA_W-1:0]  pwdata     = '0;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;

  text_console_character_engine_top dut (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .busy            (busy),
    .opcode          (opcode),
    .char_code       (char_code),
    .read_index      (read_index),
    .done            (done),
    .cell_value      (cell_value),
    .cursor_position (cursor_position),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Screen model: cells, cursor and the two registers as the block should hold them.
  logic [CELL_W-1:0] screen_model [CELLS];
  int unsigned       col_model;
  int unsigned       row_model;
  logic [ATTR_W-1:0] color_model;
  logic [BSM_W-1:0]  bs_min_model;

  rsp_t        cursor_reports_due [$];
  int unsigned mismatches      = 0;
  int unsigned reports_checked = 0;
  int unsigned requests_sent   = 0;
  int unsigned scroll_count    = 0;
  int unsigned clear_count     = 0;

  typedef struct {
    logic [OP_W-1:0]   op;
    logic [CHAR_W-1:0] ch;
    logic [IDX_W-1:0]  idx;
    bit                typed;
    rsp_t              rsp;
  } directed_row_t;

  // Directed requests; typed expectations only where they are obvious.
  directed_row_t directed_plan [26] = '{
    '{OP_READ,  8'h00, 11'd0,    1'b1, {16'h0F20, 11'd0}},
    '{OP_READ,  8'h00, 11'd1999, 1'b1, {16'h0F20, 11'd0}},
    '{OP_READ,  8'h00, 11'd2000, 1'b1, {16'h0000, 11'd0}},
    '{OP_READ,  8'hFF, 11'd2047, 1'b1, {16'h0000, 11'd0}},
    '{OP_PUT,   8'h41, 11'd0,    1'b1, {16'h0000, 11'd1}},
    '{OP_READ,  8'h00, 11'd0,    1'b1, {16'h0F41, 11'd1}},
    '{OP_PUT,   8'h20, 11'd0,    1'b1, {16'h0000, 11'd2}},
    '{OP_PUT,   8'h7F, 11'd0,    1'b1, {16'h0000, 11'd3}},
    '{OP_PUT,   8'h80, 11'd0,    1'b1, {16'h0000, 11'd3}},
    '{OP_PUT,   8'hFF, 11'd0,    1'b1, {16'h0000, 11'd3}},
    '{OP_PUT,   8'h00, 11'd0,    1'b1, {16'h0000, 11'd3}},
    '{OP_PUT,   8'h1F, 11'd0,    1'b1, {16'h0000, 11'd3}},
    '{OP_PUT,   CH_BS, 11'd0,    1'b1, {16'h0000, 11'd3}},
    '{OP_PUT,   CH_TAB, 11'd0,   1'b1, {16'h0000, 11'd8}},
    '{OP_PUT,   CH_TAB, 11'd0,   1'b1, {16'h0000, 11'd16}},
    '{OP_PUT,   CH_TAB, 11'd0,   1'b1, {16'h0000, 11'd24}},
    '{OP_PUT,   CH_BS, 11'd0,    1'b1, {16'h0000, 11'd23}},
    '{OP_PUT,   8'h7A, 11'd0,    1'b0, '0},
    '{OP_PUT,   CH_BS, 11'd0,    1'b0, '0},
    '{OP_READ,  8'h00, 11'd23,   1'b1, {16'h0F20, 11'd23}},
    '{OP_PUT,   CH_CR, 11'd0,    1'b1, {16'h0000, 11'd0}},
    '{OP_PUT,   CH_LF, 11'd0,    1'b1, {16'h0000, 11'd80}},
    '{OP_IDLE,  8'hA5, 11'd5,    1'b1, {16'h0000, 11'd80}},
    '{OP_READ,  8'h00, 11'd2,    1'b1, {16'h0F7F, 11'd80}},
    '{OP_CLEAR, 8'h00, 11'd0,    1'b1, {16'h0000, 11'd0}},
    '{OP_READ,  8'h00, 11'd0,    1'b1, {16'h0F20, 11'd0}}
  };

  function automatic void note_mismatch(input string what);
    mismatches++;
    if (mismatches <= MAX_REPORTS) begin
      $display("MISMATCH at %0t: %s", $realtime, what);
    end
  endfunction

  // Apply one request to the screen model and return the reply it should produce.
  function automatic rsp_t console_step(input logic [OP_W-1:0] op,
                                        input logic [CHAR_W-1:0] ch,
                                        input logic [IDX_W-1:0] idx);
    rsp_t        reply;
    int unsigned pos;
    logic [CELL_W-1:0] blank;
    reply.cell_data = '0;
    blank = {color_model, SPACE};
    pos = row_model * COLUMNS + col_model;
    case (op)
      OP_PUT: begin
        if (ch == CH_BS) begin
          if (col_model > bs_min_model && col_model > 0 && pos > 0) begin
            screen_model[pos - 1] = blank;
            col_model--;
          end
        end else if (ch == CH_TAB) begin
          col_model = (col_model + TAB_STEP) & ~(TAB_STEP - 1);
        end else if (ch == CH_CR) begin
          col_model = 0;
        end else if (ch == CH_LF) begin
          col_model = 0;
          row_model++;
        end else if (ch >= PRINT_LO && ch <= PRINT_HI) begin
          if (pos < CELLS) screen_model[pos] = {color_model, ch};
          col_model++;
        end
        // Wrap at the right edge, then scroll once the cursor falls off the bottom.
        if (col_model >= COLUMNS) begin
          col_model = 0;
          row_model++;
        end
        if (row_model >= ROWS) begin
          for (int i = 0; i < (ROWS - 1) * COLUMNS; i++) begin
            screen_model[i] = screen_model[i + COLUMNS];
          end
          for (int i = (ROWS - 1) * COLUMNS; i < CELLS; i++) screen_model[i] = blank;
          row_model = ROWS - 1;
          scroll_count++;
        end
      end
      OP_READ: begin
        if (idx < CELLS) reply.cell_data = screen_model[idx];
      end
      OP_CLEAR: begin
        for (int i = 0; i < CELLS; i++) screen_model[i] = blank;
        col_model = 0;
        row_model = 0;
        clear_count++;
      end
      default: ;
    endcase
    reply.pos = POS_W'(row_model * COLUMNS + col_model);
    return reply;
  endfunction

  // Mostly back-to-back requests, some short pauses and a few long ones.
  function automatic int unsigned gap_len();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 55) return 0;
    if (pick < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Hold one request until the block takes it, then record the reply it should produce.
  task automatic send_request(input logic [OP_W-1:0] op, input logic [CHAR_W-1:0] ch,
                              input logic [IDX_W-1:0] idx, input bit typed,
                              input rsp_t typed_rsp, input int unsigned gap);
    rsp_t predicted;
    start      <= 1'b1;
    opcode     <= op;
    char_code  <= ch;
    read_index <= idx;
    do @(posedge clk); while (busy);
    predicted = console_step(op, ch, idx);
    cursor_reports_due.push_back(typed ? typed_rsp : predicted);
    requests_sent++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Random request, weighted toward line feeds so the screen fills and scrolls often.
  task automatic send_random(input bit steady);
    logic [OP_W-1:0]   op;
    logic [CHAR_W-1:0] ch;
    logic [IDX_W-1:0]  idx;
    int unsigned       pick;
    int unsigned       here;
    ch = CHAR_W'($urandom);
    idx = IDX_W'($urandom);
    here = row_model * COLUMNS + col_model;
    pick = $urandom_range(0, 999);
    if (pick < 720) begin
      op = OP_PUT;
      pick = $urandom_range(0, 99);
      if (pick < 20) ch = CH_LF;
      else if (pick < 30) ch = CH_TAB;
      else if (pick < 42) ch = CH_BS;
      else if (pick < 46) ch = CH_CR;
      else if (pick < 53) ch = CHAR_W'($urandom_range(0, 31));
      else if (pick < 60) ch = CHAR_W'($urandom_range(128, 255));
      else ch = CHAR_W'($urandom_range(PRINT_LO, PRINT_HI));
    end else if (pick < 975) begin
      op = OP_READ;
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        idx = (here > 8) ? IDX_W'(here - $urandom_range(1, 8)) : IDX_W'($urandom_range(0, 8));
      end else if (pick < 92) begin
        idx = IDX_W'($urandom_range(0, CELLS - 1));
      end else begin
        idx = IDX_W'($urandom_range(CELLS, 2047));
      end
    end else if (pick < 980) begin
      op = OP_CLEAR;
    end else begin
      op = OP_IDLE;
    end
    send_request(op, ch, idx, 1'b0, '0, steady ? 0 : gap_len());
  endtask

  // Stop requesting and let every outstanding reply, and any row sweep, finish.
  task automatic wait_idle();
    start <= 1'b0;
    while (cursor_reports_due.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write one register with junk in the unused upper bits, then read it back.
  task automatic program_register(input logic [REG_W-1:0] which, input logic [BSM_W:0] value);
    logic [PDATA_W-1:0] word;
    logic [PDATA_W-1:0] kept;
    word = $urandom;
    if (which == REG_TEXT_COLOR) begin
      word[ATTR_W-1:0] = value[ATTR_W-1:0];
      kept = PDATA_W'(word[ATTR_W-1:0]);
      color_model = word[ATTR_W-1:0];
    end else begin
      word[BSM_W-1:0] = value[BSM_W-1:0];
      kept = PDATA_W'(word[BSM_W-1:0]);
      bs_min_model = word[BSM_W-1:0];
    end
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {which, 2'b00};
    pwdata  <= word;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    // Straight into the read setup phase; psel stays high.
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== kept) begin
      note_mismatch($sformatf("register %0d read back %h, wrote %h", which, prdata, kept));
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Compare every reply with the oldest outstanding expectation.
  always @(posedge clk) begin : check_reply
    rsp_t due;
    if (!rst && done) begin
      if (cursor_reports_due.size() == 0) begin
        note_mismatch($sformatf("reply with none pending: cell %h cursor %0d",
                                cell_value, cursor_position));
      end else begin
        due = cursor_reports_due.pop_front();
        reports_checked++;
        if (cell_value !== due.cell_data) begin
          note_mismatch($sformatf("cell_value %h, expected %h", cell_value, due.cell_data));
        end
        if (cursor_position !== due.pos) begin
          note_mismatch($sformatf("cursor_position %0d, expected %0d",
                                  cursor_position, due.pos));
        end
      end
    end
  end

  // Main sequence: reset, directed table, then random phases under changing registers.
  initial begin : stimulus
    logic [ATTR_W-1:0] phase_color [RANDOM_PHASES];
    logic [BSM_W-1:0]  phase_bs    [RANDOM_PHASES];
    phase_color = '{8'h00, 8'hFF, 8'h00, 8'h1E, 8'h00, 8'hA5};
    phase_bs    = '{7'd0, 7'd79, 7'd100, 7'd8, 7'd0, 7'd0};
    phase_color[2] = ATTR_W'($urandom);
    phase_color[4] = ATTR_W'($urandom);
    phase_bs[4]    = BSM_W'($urandom_range(0, COLUMNS - 1));
    for (int i = 0; i < CELLS; i++) screen_model[i] = {RST_ATTR, SPACE};
    col_model = 0;
    row_model = 0;
    color_model = RST_ATTR;
    bs_min_model = RST_BS_MIN;

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_plan[i]) begin
      send_request(directed_plan[i].op, directed_plan[i].ch, directed_plan[i].idx,
                   directed_plan[i].typed, directed_plan[i].rsp, gap_len());
    end

    // The last phase runs without any pauses on the request side.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      wait_idle();
      program_register(REG_TEXT_COLOR, phase_color[p]);
      program_register(REG_BS_MIN, {1'b0, phase_bs[p]});
      for (int n = 0; n < PHASE_ITEMS; n++) send_random(p == RANDOM_PHASES - 1);
    end

    wait_idle();
    $display("Sent %0d requests with %0d screen clears and %0d scrolls; %0d replies checked.",
             requests_sent, clear_count, scroll_count, reports_checked);
    $display("Registers went through %0d settings, %s",
             RANDOM_PHASES, "text color 0x00 to 0xFF, backspace minimum 0 to 100.");
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d mismatches in total.", mismatches);
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Hard stop far beyond the slowest legal run.
  initial begin : watchdog
    #20000000;
    $display("Timed out with %0d replies outstanding.", cursor_reports_due.size());
    $display("end of test: mismatches");
    $finish;
  end

endmodule

### text_console_character_engine_top.f
rtl/core/tcce_pkg.sv
rtl/core/tcce_ram.sv
rtl/core/tcce_front.sv
rtl/core/tcce_queue.sv
rtl/core/tcce_back.sv
rtl/core/text_console_character_engine_top.sv
dv/tb_top.sv
